// File: sv/trht_pkg.sv
// Shared types and constants for the touch rectangle hit test block.
// Used by the match unit and the top level; depends on nothing else.
package trht_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

   // Page coordinates and rectangle edges are compared at this signed width.
   localparam int COORD_W = 14;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] CSR_VIEW_LEFT   = 2'd0;
   localparam logic [1:0] CSR_VIEW_TOP    = 2'd1;
   localparam logic [1:0] CSR_VIEW_BOTTOM = 2'd2;

   localparam logic [8:0] VIEW_LEFT_RESET   = 9'd10;
   localparam logic [7:0] VIEW_TOP_RESET    = 8'd50;
   localparam logic [7:0] VIEW_BOTTOM_RESET = 8'd195;

   typedef struct packed {
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic [10:0]        width;
      logic [10:0]        height;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

endpackage

// File: sv/touch_rectangle_hit_test.sv
// Touch rectangle hit test: a table of rectangles scanned for touch queries.
// Depends on trht_pkg, trht_ram and trht_match.
//
// The req_ channel carries one beat per item: clear, insert or query. The
// rsp_ channel returns one beat per item with hit, hit_index, insert_dropped
// and entry_count. The csr_ channel writes view_left, view_top and
// view_bottom by index; an index beyond the list is ignored.
// A clear or insert item finishes in the cycle it is accepted, and its
// response beat is offered on the next cycle. A query whose touch row lies
// in the view window reads the stored rectangles one per cycle from the
// table RAM, whose registered read port sets the pace; it stops at the first
// hit or after the last stored rectangle. The block takes no
// new request while a query scans. A response beat waits in its output
// register while the receiver stalls, and a new request is taken only once
// that register is empty or being emptied in the same cycle.
// Reset empties the table, drops any pending response and restores the
// view registers to 10, 50 and 195. No clearing pass is needed.
module touch_rectangle_hit_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [11:0] req_rect_left,
   input  logic signed [11:0] req_rect_top,
   input  logic [10:0]        req_rect_width,
   input  logic [10:0]        req_rect_height,
   input  logic [8:0]         req_touch_x,
   input  logic [7:0]         req_touch_y,
   input  logic [9:0]         req_scroll_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [7:0]         rsp_hit_index,
   output logic               rsp_insert_dropped,
   output logic [8:0]         rsp_entry_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic [trht_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [trht_pkg::COUNT_W-1:0] issue_ff, issue_in;
   logic pend_valid_ff, pend_valid_in;
   logic [trht_pkg::ADDR_W-1:0] pend_idx_ff, pend_idx_in;
   trht_pkg::point_type point_ff, point_in;

   logic [8:0] view_left_ff;
   logic [7:0] view_top_ff;
   logic [7:0] view_bottom_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [7:0] rsp_hit_index_ff, rsp_hit_index_in;
   logic rsp_insert_dropped_ff, rsp_insert_dropped_in;
   logic [8:0] rsp_entry_count_ff, rsp_entry_count_in;

   logic req_fire;
   logic full;
   logic in_window;
   logic wr_en;
   logic [trht_pkg::ADDR_W-1:0] rd_addr;
   logic [trht_pkg::RECT_W-1:0] rd_data;
   trht_pkg::rect_type wr_rect;
   logic match;
   logic last;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff >= trht_pkg::COUNT_W'(trht_pkg::MAX_ENTRIES));
   assign in_window = (req_touch_y >= view_top_ff) && (req_touch_y <= view_bottom_ff);
   assign wr_en     = req_fire && (req_opcode == trht_pkg::OP_INSERT) && !full;
   assign rd_addr   = issue_ff[trht_pkg::ADDR_W-1:0];
   assign last      = (trht_pkg::COUNT_W'(pend_idx_ff) + 1'b1) == count_ff;

   always_comb begin
      wr_rect.left   = req_rect_left;
      wr_rect.top    = req_rect_top;
      wr_rect.width  = req_rect_width;
      wr_rect.height = req_rect_height;
   end

   trht_ram #(
      .WIDTH (trht_pkg::RECT_W),
      .DEPTH (trht_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[trht_pkg::ADDR_W-1:0]),
      .wr_data (wr_rect),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trht_match u_match (
      .rect  (trht_pkg::rect_type'(rd_data)),
      .point (point_ff),
      .match (match)
   );

   always_comb begin
      state_in              = state_ff;
      count_in              = count_ff;
      issue_in              = issue_ff;
      pend_valid_in         = 1'b0;
      pend_idx_in           = pend_idx_ff;
      point_in              = point_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_hit_in            = rsp_hit_ff;
      rsp_hit_index_in      = rsp_hit_index_ff;
      rsp_insert_dropped_in = rsp_insert_dropped_ff;
      rsp_entry_count_in    = rsp_entry_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in          = 1'b1;
               rsp_hit_in            = 1'b0;
               rsp_hit_index_in      = 8'd0;
               rsp_insert_dropped_in = 1'b0;
               rsp_entry_count_in    = 9'(count_ff);
               case (req_opcode)
                  trht_pkg::OP_CLEAR: begin
                     count_in           = '0;
                     rsp_entry_count_in = 9'd0;
                  end
                  trht_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_insert_dropped_in = 1'b1;
                     end else begin
                        count_in           = count_ff + 1'b1;
                        rsp_entry_count_in = 9'(count_ff + 1'b1);
                     end
                  end
                  trht_pkg::OP_QUERY: begin
                     point_in.x = $signed({{(trht_pkg::COORD_W-9){1'b0}}, req_touch_x})
                                - $signed({{(trht_pkg::COORD_W-9){1'b0}}, view_left_ff});
                     point_in.y = $signed({{(trht_pkg::COORD_W-8){1'b0}}, req_touch_y})
                                - $signed({{(trht_pkg::COORD_W-8){1'b0}}, view_top_ff})
                                + $signed({{(trht_pkg::COORD_W-10){1'b0}}, req_scroll_offset});
                     if (in_window && (count_ff != '0)) begin
                        rsp_valid_in = 1'b0;
                        issue_in     = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_in      = issue_ff + 1'b1;
               pend_valid_in = 1'b1;
               pend_idx_in   = issue_ff[trht_pkg::ADDR_W-1:0];
            end
            if (pend_valid_ff && (match || last)) begin
               pend_valid_in         = 1'b0;
               state_in              = ST_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_hit_in            = match;
               rsp_hit_index_in      = match ? 8'(pend_idx_ff) : 8'd0;
               rsp_insert_dropped_in = 1'b0;
               rsp_entry_count_in    = 9'(count_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         issue_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         view_left_ff   <= trht_pkg::VIEW_LEFT_RESET;
         view_top_ff    <= trht_pkg::VIEW_TOP_RESET;
         view_bottom_ff <= trht_pkg::VIEW_BOTTOM_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               trht_pkg::CSR_VIEW_LEFT:   view_left_ff   <= csr_data;
               trht_pkg::CSR_VIEW_TOP:    view_top_ff    <= csr_data[7:0];
               trht_pkg::CSR_VIEW_BOTTOM: view_bottom_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff           <= pend_idx_in;
      point_ff              <= point_in;
      rsp_hit_ff            <= rsp_hit_in;
      rsp_hit_index_ff      <= rsp_hit_index_in;
      rsp_insert_dropped_ff <= rsp_insert_dropped_in;
      rsp_entry_count_ff    <= rsp_entry_count_in;
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_index      = rsp_hit_index_ff;
   assign rsp_insert_dropped = rsp_insert_dropped_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;

endmodule

// File: sv/trht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Self-contained; no package is used.
module trht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/trht_match.sv
// Containment test of one page point against one stored rectangle.
// Edges count as inside. Depends on trht_pkg.
module trht_match (
   input  trht_pkg::rect_type  rect,
   input  trht_pkg::point_type point,
   output logic                match
);

   logic signed [trht_pkg::COORD_W-1:0] left;
   logic signed [trht_pkg::COORD_W-1:0] top;
   logic signed [trht_pkg::COORD_W-1:0] right;
   logic signed [trht_pkg::COORD_W-1:0] bottom;

   always_comb begin
      left   = trht_pkg::COORD_W'(rect.left);
      top    = trht_pkg::COORD_W'(rect.top);
      right  = left + $signed({{(trht_pkg::COORD_W-11){1'b0}}, rect.width});
      bottom = top + $signed({{(trht_pkg::COORD_W-11){1'b0}}, rect.height});
      match  = (point.x >= left) && (point.x <= right) &&
               (point.y >= top) && (point.y <= bottom);
   end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the touch rectangle hit test block.
// Depends on trht_pkg and touch_rectangle_hit_test; predicts every response beat
// and checks it field by field.
module testbench;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int TOUCH_X_MAX    = 319;
   localparam int TOUCH_Y_MAX    = 239;
   localparam int SCROLL_MAX     = 1023;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int PHASES         = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct packed {
      logic [1:0]         opcode;
      trht_pkg::rect_type rect;
      logic [8:0]         touch_x;
      logic [7:0]         touch_y;
      logic [9:0]         scroll_offset;
   } touch_item_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] hit_index;
      logic       insert_dropped;
      logic [8:0] entry_count;
   } hit_result_type;

   typedef struct packed {
      touch_item_type item;
      logic           known;
      hit_result_type want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = trht_pkg::OP_CLEAR;
   logic signed [11:0] req_rect_left = '0;
   logic signed [11:0] req_rect_top = '0;
   logic [10:0]        req_rect_width = '0;
   logic [10:0]        req_rect_height = '0;
   logic [8:0]         req_touch_x = '0;
   logic [7:0]         req_touch_y = '0;
   logic [9:0]         req_scroll_offset = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [7:0]         rsp_hit_index;
   logic               rsp_insert_dropped;
   logic [8:0]         rsp_entry_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = trht_pkg::CSR_VIEW_LEFT;
   logic [8:0]         csr_data = '0;

   trht_pkg::rect_type rect_table [trht_pkg::MAX_ENTRIES];
   int                 stored_rects = 0;
   logic [8:0]         view_left = trht_pkg::VIEW_LEFT_RESET;
   logic [7:0]         view_top = trht_pkg::VIEW_TOP_RESET;
   logic [7:0]         view_bottom = trht_pkg::VIEW_BOTTOM_RESET;

   hit_result_type   predicted_responses [$];
   directed_row_type directed_rows [$];
   int               mismatches = 0;
   int               responses_seen = 0;
   int               items_sent = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   logic             hold_off_pending = 1'b0;
   logic             hold_off_done = 1'b0;

   touch_rectangle_hit_test DUT (.*);

   always #5 clock = ~clock;

   function automatic hit_result_type predict_hit_result(touch_item_type it);
      hit_result_type     res;
      trht_pkg::rect_type r;
      int                 px;
      int                 py;
      int                 lft;
      int                 tp;
      res = '0;
      case (it.opcode)
         trht_pkg::OP_CLEAR: stored_rects = 0;
         trht_pkg::OP_INSERT: begin
            if (stored_rects < trht_pkg::MAX_ENTRIES) begin
               rect_table[stored_rects] = it.rect;
               stored_rects++;
            end else begin
               res.insert_dropped = 1'b1;
            end
         end
         trht_pkg::OP_QUERY: begin
            if (it.touch_y >= view_top && it.touch_y <= view_bottom) begin
               px = int'(it.touch_x) - int'(view_left);
               py = int'(it.touch_y) - int'(view_top) + int'(it.scroll_offset);
               for (int i = 0; i < stored_rects && !res.hit; i++) begin
                  r = rect_table[i];
                  lft = int'($signed(r.left));
                  tp = int'($signed(r.top));
                  if (px >= lft && px <= lft + int'(r.width) &&
                      py >= tp && py <= tp + int'(r.height)) begin
                     res.hit = 1'b1;
                     res.hit_index = 8'(i);
                  end
               end
            end
         end
         default: ;
      endcase
      res.entry_count = 9'(stored_rects);
      return res;
   endfunction

   function automatic void apply_view_write(logic [1:0] index, logic [8:0] data);
      case (index)
         trht_pkg::CSR_VIEW_LEFT:   view_left = data;
         trht_pkg::CSR_VIEW_TOP:    view_top = data[7:0];
         trht_pkg::CSR_VIEW_BOTTOM: view_bottom = data[7:0];
         default: ;
      endcase
   endfunction

   function automatic void add_row(logic [1:0] op, int left, int top, int width, int height,
                                   int tx, int ty, int sc, logic known, int hit, int idx,
                                   int count);
      directed_row_type row;
      row = '0;
      row.item.opcode = op;
      row.item.rect.left = 12'(left);
      row.item.rect.top = 12'(top);
      row.item.rect.width = 11'(width);
      row.item.rect.height = 11'(height);
      row.item.touch_x = 9'(tx);
      row.item.touch_y = 8'(ty);
      row.item.scroll_offset = 10'(sc);
      row.known = known;
      row.want.hit = 1'(hit);
      row.want.hit_index = 8'(idx);
      row.want.entry_count = 9'(count);
      directed_rows.push_back(row);
   endfunction

   function automatic touch_item_type random_fields(logic [1:0] op);
      touch_item_type it;
      it.opcode = op;
      it.rect.left = 12'($urandom);
      it.rect.top = 12'($urandom);
      it.rect.width = 11'($urandom);
      it.rect.height = 11'($urandom);
      it.touch_x = 9'($urandom_range(TOUCH_X_MAX));
      it.touch_y = 8'($urandom_range(TOUCH_Y_MAX));
      it.scroll_offset = 10'($urandom_range(SCROLL_MAX));
      return it;
   endfunction

   function automatic touch_item_type make_insert();
      touch_item_type it;
      it = random_fields(trht_pkg::OP_INSERT);
      if ($urandom_range(7) != 0) begin
         it.rect.left = 12'(int'($urandom_range(660)) - 340);
         it.rect.top = 12'(int'($urandom_range(1300)) - 20);
         it.rect.width = ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
                                                  : 11'($urandom_range(120));
         it.rect.height = ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
                                                   : 11'($urandom_range(300));
      end
      return it;
   endfunction

   function automatic int pick_span(int lo, int span);
      case ($urandom_range(5))
         0: return lo;
         1: return lo + span;
         2: return lo - 1;
         3: return lo + span + 1;
         default: return lo + int'($urandom_range(span));
      endcase
   endfunction

   // Most queries aim at a stored rectangle, often at or just past one of its edges.
   function automatic touch_item_type make_query();
      touch_item_type     it;
      trht_pkg::rect_type r;
      int                 tx_i;
      int                 sc_i;
      int                 px;
      int                 py;
      it = random_fields(trht_pkg::OP_QUERY);
      if (view_top <= view_bottom && $urandom_range(3) != 0)
         it.touch_y = 8'($urandom_range(view_bottom, view_top));
      if (stored_rects > 0 && $urandom_range(3) != 0) begin
         r = rect_table[$urandom_range(stored_rects - 1)];
         px = pick_span(int'($signed(r.left)), int'(r.width));
         py = pick_span(int'($signed(r.top)), int'(r.height));
         tx_i = px + int'(view_left);
         if (tx_i >= 0 && tx_i <= TOUCH_X_MAX)
            it.touch_x = 9'(tx_i);
         sc_i = py - (int'(it.touch_y) - int'(view_top));
         if (sc_i >= 0 && sc_i <= SCROLL_MAX)
            it.scroll_offset = 10'(sc_i);
      end
      return it;
   endfunction

   task automatic send_item(input touch_item_type it, input logic known,
                            input hit_result_type want);
      hit_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_rect_left <= it.rect.left;
      req_rect_top <= it.rect.top;
      req_rect_width <= it.rect.width;
      req_rect_height <= it.rect.height;
      req_touch_x <= it.touch_x;
      req_touch_y <= it.touch_y;
      req_scroll_offset <= it.scroll_offset;
      do @(negedge clock); while (!req_ready);
      predicted = predict_hit_result(it);
      predicted_responses.push_back(known ? want : predicted);
      if (it.opcode != OP_UNUSED)
         items_sent++;
      @(posedge clock);
   endtask

   task automatic write_view(input logic [1:0] index, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(negedge clock); while (!csr_ready);
      apply_view_write(index, data);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_responses.size() != 0);
   endtask

   task automatic run_sequence();
      int kind;
      int n;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         if (kind != 6)
            send_item(random_fields(trht_pkg::OP_CLEAR), 1'b0, '0);
         n = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         repeat (n) send_item(make_insert(), 1'b0, '0);
         repeat ($urandom_range(10, 2)) send_item(make_query(), 1'b0, '0);
      end else begin
         repeat ($urandom_range(6, 1))
            send_item(random_fields(2'($urandom_range(3))), 1'b0, '0);
      end
   endtask

   task automatic fill_table();
      send_item(random_fields(trht_pkg::OP_CLEAR), 1'b0, '0);
      repeat (trht_pkg::MAX_ENTRIES + $urandom_range(6, 1))
         send_item(make_insert(), 1'b0, '0);
      repeat (20) send_item(make_query(), 1'b0, '0);
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR: response %0d: %s", responses_seen, what);
      mismatches++;
   endtask

   // Each response beat is matched against the oldest prediction.
   always @(negedge clock) begin : check_responses
      hit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_responses.size() == 0) begin
            report_mismatch("response beat with no item outstanding");
         end else begin
            want = predicted_responses.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit got %0d, expected %0d", rsp_hit, want.hit));
            if (rsp_hit_index !== want.hit_index)
               report_mismatch($sformatf("hit_index got %0d, expected %0d",
                                         rsp_hit_index, want.hit_index));
            if (rsp_insert_dropped !== want.insert_dropped)
               report_mismatch($sformatf("insert_dropped got %0d, expected %0d",
                                         rsp_insert_dropped, want.insert_dropped));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                         rsp_entry_count, want.entry_count));
         end
         responses_seen++;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending && !hold_off_done) begin
            hold_off_done <= 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int goal;
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,  10, 100,    0, 1'b1, 0, 0, 0);
      add_row(OP_UNUSED,            -100,   300,   50,   60, 319, 239, 1023, 1'b1, 0, 0, 0);
      add_row(trht_pkg::OP_CLEAR,      0,     0,    0,    0,   0,   0,    0, 1'b1, 0, 0, 0);
      add_row(trht_pkg::OP_INSERT, -2048, -2048, 2047, 2047,   0,   0,    0, 1'b1, 0, 0, 1);
      add_row(trht_pkg::OP_INSERT,  2047,  2047, 2047, 2047,   0,   0,    0, 1'b1, 0, 0, 2);
      add_row(trht_pkg::OP_INSERT,     0,     0,    0,    0,   0,   0,    0, 1'b1, 0, 0, 3);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,  10,  50,    0, 1'b1, 1, 2, 3);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   9,  50,    0, 1'b1, 0, 0, 3);
      add_row(trht_pkg::OP_INSERT,   -10,   100,    5,   20,   0,   0,    0, 1'b1, 0, 0, 4);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   0,  50,  100, 1'b1, 1, 3, 4);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   5,  70,  100, 1'b1, 1, 3, 4);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   6,  70,  100, 1'b1, 0, 0, 4);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   0,  71,  100, 1'b1, 0, 0, 4);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,   0,  49,  101, 1'b1, 0, 0, 4);
      add_row(trht_pkg::OP_INSERT,   309,  1000,    0,  262,   0,   0,    0, 1'b1, 0, 0, 5);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0, 319, 195, 1023, 1'b1, 1, 4, 5);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0, 319, 196, 1023, 1'b1, 0, 0, 5);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0, 319, 239,    0, 1'b1, 0, 0, 5);
      add_row(OP_UNUSED,            2047, -2048,    0, 2047,   0, 100,  512, 1'b1, 0, 0, 5);
      add_row(trht_pkg::OP_INSERT,  -320,   -20, 1024,  511, 255, 170,  682, 1'b0, 0, 0, 0);
      add_row(trht_pkg::OP_QUERY,   1365,  -683,  682, 1365,  10, 120,  341, 1'b0, 0, 0, 0);
      add_row(trht_pkg::OP_CLEAR,      0,     0,    0,    0,   0,   0,    0, 1'b1, 0, 0, 0);
      add_row(trht_pkg::OP_QUERY,      0,     0,    0,    0,  10,  50,    0, 1'b1, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_item(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);
      goal = items_sent;

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            1: begin
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'd0);
               write_view(trht_pkg::CSR_VIEW_TOP, 9'd0);
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'd239);
            end
            2: begin
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'd319);
               write_view(trht_pkg::CSR_VIEW_TOP, 9'd239);
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'd239);
            end
            3: begin
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'd160);
               write_view(trht_pkg::CSR_VIEW_TOP, 9'd200);
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'd40);
            end
            5: begin
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'd0);
               write_view(trht_pkg::CSR_VIEW_TOP, 9'd0);
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'd0);
            end
            6: begin
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'd319);
               write_view(trht_pkg::CSR_VIEW_TOP, 9'd0);
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'd239);
            end
            4, 7: begin
               write_view(CSR_UNUSED, 9'($urandom));
               write_view(trht_pkg::CSR_VIEW_LEFT, 9'($urandom_range(TOUCH_X_MAX)));
               write_view(trht_pkg::CSR_VIEW_TOP, 9'($urandom_range(TOUCH_Y_MAX)));
               write_view(trht_pkg::CSR_VIEW_BOTTOM, 9'($urandom_range(TOUCH_Y_MAX)));
            end
            default: ;
         endcase
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
            default: begin send_idle_pct = 15; recv_stall_pct <= 15; end
         endcase
         if (phase == 2)
            hold_off_pending <= 1'b1;
         if (phase == 1 || phase == 5)
            fill_table();
         goal += RANDOM_ITEMS / PHASES;
         while (items_sent < goal)
            run_sequence();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
